// File: rtl/button_press_classifier_defines.svh
// Assertion helpers used by the checker file.
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define BPC_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define BPC_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bpc_pkg.sv
package bpc_pkg;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2,
    EV_HELD  = 2'd3
  } bpc_event_e;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_IVL = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_POLLS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_LEVEL = 4'd3;

  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [15:0] REPEAT_IVL_RST = 16'd500;
  localparam logic [7:0]  HOLD_POLLS_RST = 8'd150;
  localparam logic        INIT_LEVEL_RST = 1'b1;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] repeat_interval_ms;
    logic [7:0]  event_hold_polls;
    logic        init_load;   // preset of the previous level this cycle
    logic        init_level;
  } bpc_cfg_t;

  typedef struct packed {
    logic        prev_level;
    logic [31:0] press_start;
    logic [31:0] repeat_ref;
    bpc_event_e  event_code;
    logic [7:0]  repeat_counter;
    logic [7:0]  lock_counter;
  } bpc_state_t;

endpackage

// File: rtl/bpc_cfg.sv
module bpc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output bpc_pkg::bpc_cfg_t                 cfg_o
);

  logic [15:0] long_press_q;
  logic [15:0] repeat_ivl_q;
  logic [7:0]  hold_polls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= bpc_pkg::LONG_PRESS_RST;
      repeat_ivl_q <= bpc_pkg::REPEAT_IVL_RST;
      hold_polls_q <= bpc_pkg::HOLD_POLLS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpc_pkg::REG_LONG_PRESS: long_press_q <= cfg_wdata_i;
        bpc_pkg::REG_REPEAT_IVL: repeat_ivl_q <= cfg_wdata_i;
        bpc_pkg::REG_HOLD_POLLS: hold_polls_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.long_press_ms      = long_press_q;
    cfg_o.repeat_interval_ms = repeat_ivl_q;
    cfg_o.event_hold_polls   = hold_polls_q;
    cfg_o.init_load          = cfg_we_i && (cfg_idx_i == bpc_pkg::REG_INIT_LEVEL);
    cfg_o.init_level         = cfg_wdata_i[0];
  end

endmodule

// File: rtl/bpc_classify.sv
module bpc_classify (
  input  bpc_pkg::bpc_cfg_t   cfg_i,
  input  bpc_pkg::bpc_state_t cur_i,
  input  logic                level_i,
  input  logic [31:0]         now_ms_i,
  output bpc_pkg::bpc_state_t nxt_o
);

  logic [31:0] age_ref;
  logic [31:0] age_press;

  // Wrapping durations, modulo 2^32.
  assign age_ref   = now_ms_i - cur_i.repeat_ref;
  assign age_press = now_ms_i - cur_i.press_start;

  always_comb begin
    logic [7:0] lock_inc;
    nxt_o = cur_i;
    if (!level_i) begin
      if (cur_i.prev_level) begin
        nxt_o.press_start    = now_ms_i;
        nxt_o.repeat_ref     = now_ms_i;
        nxt_o.repeat_counter = '0;
      end else if (age_ref > {16'd0, cfg_i.repeat_interval_ms}) begin
        nxt_o.repeat_ref     = now_ms_i;
        nxt_o.event_code     = bpc_pkg::EV_HELD;
        nxt_o.repeat_counter = cur_i.repeat_counter + 8'd1;
      end
    end else if (!cur_i.prev_level) begin
      nxt_o.event_code   = (age_press > {16'd0, cfg_i.long_press_ms}) ?
                           bpc_pkg::EV_LONG : bpc_pkg::EV_SHORT;
      nxt_o.lock_counter = '0;
    end
    nxt_o.prev_level = level_i;

    // Short and long events time out after the programmed poll count.
    lock_inc = nxt_o.lock_counter + 8'd1;
    if (nxt_o.event_code == bpc_pkg::EV_SHORT || nxt_o.event_code == bpc_pkg::EV_LONG) begin
      if (lock_inc >= cfg_i.event_hold_polls) begin
        nxt_o.event_code   = bpc_pkg::EV_NONE;
        nxt_o.lock_counter = '0;
      end else begin
        nxt_o.lock_counter = lock_inc;
      end
    end
  end

endmodule

// File: rtl/button_press_classifier.sv
// Channel   | Dir | Handshake                 | Payload
// ----------+-----+---------------------------+------------------------------
// poll in   | in  | in_valid_i / in_ready_o   | level_i, now_ms_i
// result    | out | out_valid_o / out_ready_i | event_res_o, repeat_count_o
// config    | in  | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One poll per clock sustained while the result side is not stalled; each beat passes
// from the input register through the classifier into the result register.
// Reset (rst_ni low, async) clears the press state, empties both stages and
// loads the register defaults; the previous level comes up released.
// A stalled result register holds; one more poll is still taken into the input
// register, after which in_ready_o drops until the result beat is taken.
module button_press_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           level_i,
  input  logic [31:0]                    now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     event_res_o,
  output logic [7:0]                     repeat_count_o,
  input  logic                           cfg_we_i,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  bpc_pkg::bpc_cfg_t   cfg;
  bpc_pkg::bpc_state_t state_q, state_d, state_nxt;

  // Input register
  logic        s1_valid_q, s1_valid_d;
  logic        s1_level_q;
  logic [31:0] s1_now_q;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_event_q;
  logic [7:0]  out_count_q;

  logic in_fire;
  logic out_adv;   // result register can take a new beat
  logic s1_fire;   // input register beat is processed this cycle

  bpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bpc_classify u_classify (
    .cfg_i    (cfg),
    .cur_i    (state_q),
    .level_i  (s1_level_q),
    .now_ms_i (s1_now_q),
    .nxt_o    (state_nxt)
  );

  assign out_adv    = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_adv;
  assign in_ready_o = !s1_valid_q || out_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // State advances once per processed beat; a write of the assumed level
  // presets prev_level (only while idle, a rule for the user that the block does not enforce).
  always_comb begin
    state_d = state_q;
    if (cfg.init_load) begin
      state_d.prev_level = cfg.init_level;
    end else if (s1_fire) begin
      state_d = state_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q               <= 1'b0;
      out_valid_q              <= 1'b0;
      state_q.prev_level       <= bpc_pkg::INIT_LEVEL_RST;
      state_q.press_start      <= '0;
      state_q.repeat_ref       <= '0;
      state_q.event_code       <= bpc_pkg::EV_NONE;
      state_q.repeat_counter   <= '0;
      state_q.lock_counter     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_level_q <= level_i;
      s1_now_q   <= now_ms_i;
    end
    if (s1_fire) begin
      out_event_q <= state_nxt.event_code;
      out_count_q <= state_nxt.repeat_counter;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = out_event_q;
  assign repeat_count_o = out_count_q;

endmodule

// File: rtl/bpc_checker.sv
`include "button_press_classifier_defines.svh"

module bpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] event_res_o,
  input logic [7:0] repeat_count_o
);

  logic       out_stall;
  logic       in_fire;
  logic [9:0] out_payload;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_payload = {event_res_o, repeat_count_o};

  // A stalled result beat stays up and keeps its payload.
  `BPC_ASSERT_NXT(a_out_hold, out_stall, out_valid_o, "result beat dropped while stalled")
  `BPC_ASSERT_NXT(a_out_data, out_stall, $stable(out_payload), "stalled result payload changed")

  // Input side backs up only when both stages are full and the result is stalled.
  `BPC_ASSERT_IMP(a_ready_low, !in_ready_o, out_stall, "input stalled with room in the pipe")

  // A new result appears only when a poll beat was taken and has passed the input register.
  `BPC_ASSERT_IMP(a_out_src, $rose(out_valid_o), $past(in_fire, 2), "result without a poll")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

// File: sim/tb_button_press_classifier.sv
`timescale 1ns / 1ps

// Poll stream in, one result beat out per poll. A local model of the press
// classifier predicts each result when its poll beat is accepted; a separate
// process checks result beats against the oldest prediction.
module tb_button_press_classifier;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 32;
  // settle time after the last result: two-stage pipe plus margin
  localparam int unsigned SETTLE_CYC  = 4;
  localparam int unsigned IDX_W       = bpc_pkg::CFG_IDX_W;
  localparam int unsigned DATA_W      = bpc_pkg::CFG_DATA_W;

  typedef struct packed {
    bpc_pkg::bpc_event_e ev;
    logic [7:0]          cnt;
  } poll_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              level_i;
  logic [31:0]       now_ms_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        event_res_o;
  logic [7:0]        repeat_count_o;
  logic              cfg_we_i;
  logic [IDX_W-1:0]  cfg_idx_i;
  logic [DATA_W-1:0] cfg_wdata_i;

  button_press_classifier dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .level_i        (level_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .repeat_count_o (repeat_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Local copy of the classifier: registers and press state
  // ---------------------------------------------------------------------
  logic [15:0] cfg_long_ms;
  logic [15:0] cfg_repeat_ms;
  logic [7:0]  cfg_hold_polls;
  logic        cfg_init_level;

  logic                m_prev_level;
  logic [31:0]         m_press_start;
  logic [31:0]         m_repeat_ref;
  bpc_pkg::bpc_event_e m_event;
  logic [7:0]          m_repeat_cnt;
  logic [7:0]          m_lock_cnt;

  poll_result_t pending_results[$];
  int unsigned  err_count = 0;
  int unsigned  cycle_count = 0;
  bit           idle_on = 1'b1;   // random gaps on both sides when set
  logic [31:0]  t_ms;             // running millisecond clock for random traffic

  function automatic void reset_model();
    cfg_long_ms    = bpc_pkg::LONG_PRESS_RST;
    cfg_repeat_ms  = bpc_pkg::REPEAT_IVL_RST;
    cfg_hold_polls = bpc_pkg::HOLD_POLLS_RST;
    cfg_init_level = bpc_pkg::INIT_LEVEL_RST;
    m_prev_level   = bpc_pkg::INIT_LEVEL_RST;
    m_press_start  = '0;
    m_repeat_ref   = '0;
    m_event        = bpc_pkg::EV_NONE;
    m_repeat_cnt   = '0;
    m_lock_cnt     = '0;
  endfunction

  // One poll: edge / hold handling, then the short/long self-clear.
  function automatic poll_result_t predict_poll(input logic lvl, input logic [31:0] t);
    logic [31:0]  since_ref;
    logic [31:0]  since_press;
    poll_result_t r;
    since_ref   = t - m_repeat_ref;    // mod 2^32
    since_press = t - m_press_start;
    if (!lvl) begin
      if (m_prev_level) begin
        // falling edge: new press
        m_press_start = t;
        m_repeat_ref  = t;
        m_repeat_cnt  = '0;
      end else if (since_ref > {16'd0, cfg_repeat_ms}) begin
        m_repeat_ref = t;
        m_event      = bpc_pkg::EV_HELD;
        m_repeat_cnt = m_repeat_cnt + 8'd1;
      end
    end else if (!m_prev_level) begin
      // release: classify by duration
      m_event    = (since_press > {16'd0, cfg_long_ms}) ?
                   bpc_pkg::EV_LONG : bpc_pkg::EV_SHORT;
      m_lock_cnt = '0;
    end
    m_prev_level = lvl;
    // held stays put; short/long clears after the hold count
    if (m_event == bpc_pkg::EV_SHORT || m_event == bpc_pkg::EV_LONG) begin
      m_lock_cnt = m_lock_cnt + 8'd1;
      if (m_lock_cnt >= cfg_hold_polls) begin
        m_event    = bpc_pkg::EV_NONE;
        m_lock_cnt = '0;
      end
    end
    r.ev  = m_event;
    r.cnt = m_repeat_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Predict on every accepted poll beat
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      pending_results.push_back(predict_poll(level_i, now_ms_i));
  end

  // ---------------------------------------------------------------------
  // Check every accepted result beat against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    poll_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction pending");
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (event_res_o !== exp_r.ev) begin
          $error("event_res: expected %0d, actual %0d", exp_r.ev, event_res_o);
          err_count++;
        end
        if (repeat_count_o !== exp_r.cnt) begin
          $error("repeat_count: expected %0d, actual %0d", exp_r.cnt, repeat_count_o);
          err_count++;
        end
      end
    end
  end

  // Result side: random stalls unless idling is off.
  always @(posedge clk_i)
    out_ready_i <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------

  // Called just after a rising edge; returns just after the edge that took the beat.
  task automatic send_poll(input logic lvl, input logic [31:0] t);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    level_i    <= lvl;
    now_ms_i   <= t;
    // inputs only move at rising edges, so the negedge value holds at the next edge
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  // Wait until every predicted result is out, then let the pipe settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Only while idle. Drops the write enable after the write, then updates the model copy.
  task automatic program_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      bpc_pkg::REG_LONG_PRESS: cfg_long_ms    = data;
      bpc_pkg::REG_REPEAT_IVL: cfg_repeat_ms  = data;
      bpc_pkg::REG_HOLD_POLLS: cfg_hold_polls = data[7:0];
      bpc_pkg::REG_INIT_LEVEL: begin
        cfg_init_level = data[0];
        m_prev_level   = data[0];   // write presets the previous level
      end
      default: ;
    endcase
  endtask

  // All four registers; unused upper data bits get random junk.
  task automatic load_config(input logic [15:0] long_ms, input logic [15:0] rep_ms,
                             input logic [7:0] hold, input logic lvl);
    drain_results();
    program_reg(bpc_pkg::REG_LONG_PRESS, long_ms);
    program_reg(bpc_pkg::REG_REPEAT_IVL, rep_ms);
    program_reg(bpc_pkg::REG_HOLD_POLLS, {8'($urandom), hold});
    program_reg(bpc_pkg::REG_INIT_LEVEL, {15'($urandom), lvl});
  endtask

  // Per-poll time advance scaled to the current thresholds.
  function automatic logic [31:0] time_step();
    int unsigned span;
    span = ((cfg_long_ms > cfg_repeat_ms) ? cfg_long_ms : cfg_repeat_ms) / 4 + 4;
    return $urandom_range(0, span);
  endfunction

  // Mostly press/release sequences, some noise with random levels and time jumps.
  task automatic run_press_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_low;
    int unsigned n_high;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        n_low  = $urandom_range(1, 8);
        n_high = $urandom_range(1, 6);
        repeat (n_low) begin
          t_ms += time_step();
          send_poll(1'b0, t_ms);
        end
        repeat (n_high) begin
          t_ms += time_step();
          send_poll(1'b1, t_ms);
        end
        sent += n_low + n_high;
      end else begin
        if ($urandom_range(0, 3) == 0) t_ms = $urandom;
        else                           t_ms += $urandom_range(0, 3);
        send_poll(1'($urandom_range(0, 1)), t_ms);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // prev level preset low: release with no press measures from press_start (0)
  task automatic test_release_without_press();
    drain_results();
    program_reg(bpc_pkg::REG_INIT_LEVEL, {15'($urandom), 1'b0});
    send_poll(1'b1, 32'd5);         // short
    send_poll(1'b1, 32'd10);        // still short, lock counting
    drain_results();
    program_reg(bpc_pkg::REG_INIT_LEVEL, {15'($urandom), 1'b1});
  endtask

  // Defaults: thresholds are strict, exact values stay short / no repeat
  task automatic test_press_durations();
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'd100);       // press
    send_poll(1'b0, 32'd600);       // exactly the interval: no repeat
    send_poll(1'b0, 32'd601);       // held, count 1
    send_poll(1'b1, 32'd1100);      // exactly long threshold: short
    send_poll(1'b0, 32'd2000);
    send_poll(1'b1, 32'd3001);      // one over: long
  endtask

  // Press just before 2^32, repeat and release after the wrap
  task automatic test_time_wrap();
    send_poll(1'b0, 32'hFFFF_FF00);
    send_poll(1'b0, 32'h0000_0100); // 512 > 500: held
    send_poll(1'b1, 32'h0000_0400); // 1280 > 1000: long
  endtask

  // Hold count zero: short/long never seen. Then hold two: seen for one poll.
  task automatic test_hold_count();
    load_config(bpc_pkg::LONG_PRESS_RST, bpc_pkg::REPEAT_IVL_RST, 8'd0, 1'b1);
    send_poll(1'b0, 32'h1000_0000);
    send_poll(1'b1, 32'h1000_0005);
    load_config(bpc_pkg::LONG_PRESS_RST, bpc_pkg::REPEAT_IVL_RST, 8'd2, 1'b1);
    send_poll(1'b0, 32'h1000_0010);
    send_poll(1'b1, 32'h1000_0020);
    send_poll(1'b1, 32'h1000_0030); // clears here
  endtask

  task automatic test_reg_extremes();
    load_config(16'd0, 16'd0, 8'd255, 1'b1);
    send_poll(1'b0, 32'h8000_0000);
    send_poll(1'b0, 32'h8000_0000); // zero elapsed: no repeat
    send_poll(1'b0, 32'h8000_0001); // held
    send_poll(1'b1, 32'h8000_0001); // 1 > 0: long
    load_config(16'hFFFF, 16'hFFFF, 8'd255, 1'b1);
    send_poll(1'b0, 32'h0F00_0000);
    send_poll(1'b0, 32'h0F00_FFFF); // 65535: no repeat
    send_poll(1'b0, 32'h0F01_0000); // held
    send_poll(1'b1, 32'h0F00_FFFF); // 65535 not above: short
  endtask

  // Writes above the last register must change nothing
  task automatic test_unknown_index();
    drain_results();
    for (int idx = bpc_pkg::REG_INIT_LEVEL + 1; idx < (1 << IDX_W); idx++)
      program_reg(IDX_W'(idx), DATA_W'($urandom));
    send_poll(1'b0, 32'h2000_0000);
    send_poll(1'b1, 32'h2000_07D0);
  endtask

  // ---------------------------------------------------------------------
  // Random tests
  // ---------------------------------------------------------------------

  // Several register settings, extremes first
  task automatic test_random_phases();
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       load_config(16'd0, 16'd0, 8'd1, 1'($urandom_range(0, 1)));
        1:       load_config(16'hFFFF, 16'hFFFF, 8'd255, 1'($urandom_range(0, 1)));
        2:       load_config(16'hFFFF, 16'd0, 8'($urandom_range(1, 8)), 1'b1);
        default: load_config(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 1500)),
                             8'($urandom_range(0, 20)), 1'($urandom_range(0, 1)));
      endcase
      run_press_traffic(100);
    end
  endtask

  // Long stretch with both sides streaming flat out
  task automatic test_no_idle();
    load_config(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 800)),
                8'($urandom_range(1, 10)), 1'b1);
    idle_on = 1'b0;
    run_press_traffic(250);
    drain_results();
    idle_on = 1'b1;
  endtask

  // Zero interval: a repeat on every held poll, so the count wraps past 255
  task automatic test_repeat_wrap();
    load_config(16'($urandom_range(0, 2000)), 16'd0, 8'($urandom_range(1, 10)), 1'b1);
    t_ms = $urandom;
    send_poll(1'b0, t_ms);
    repeat (270) begin
      t_ms += $urandom_range(1, 3);
      send_poll(1'b0, t_ms);
    end
    t_ms += $urandom_range(0, 3);
    send_poll(1'b1, t_ms);
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    level_i     = 1'b1;
    now_ms_i    = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = bpc_pkg::REG_LONG_PRESS;
    cfg_wdata_i = '0;
    reset_model();
    t_ms = $urandom;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_release_without_press();
    test_press_durations();
    test_time_wrap();
    test_hold_count();
    test_reg_extremes();
    test_unknown_index();
    test_random_phases();
    test_no_idle();
    test_repeat_wrap();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      err_count++;
    end
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
